[rtl/core/rpnos_pkg.sv]
// Shared types and constants for the RPN operand stack.
`timescale 1ns / 1ps
package rpnos_pkg;

  localparam int DATA_W    = 64;
  localparam int KIND_W    = 4;
  localparam int CNT_W     = 8;
  localparam int ENTRIES_W = 7;
  localparam int ERR_W     = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH  = 4'd0,
    KIND_POP   = 4'd1,
    KIND_PICK  = 4'd2,
    KIND_DROP  = 4'd3,
    KIND_DUP   = 4'd4,
    KIND_DUP2  = 4'd5,
    KIND_DUPN  = 4'd6,
    KIND_DROPN = 4'd7,
    KIND_CLEAR = 4'd8,
    KIND_OVER  = 4'd9,
    KIND_DEPTH = 4'd10,
    KIND_SWAP  = 4'd11,
    KIND_ROLL  = 4'd12
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_PICK,
    S_LOAD,
    S_PUSH,
    S_DONE
  } state_t;

  // Holding registers for popped or picked words.
  typedef enum logic [1:0] {
    SLOT_A = 2'd0,
    SLOT_B = 2'd1,
    SLOT_C = 2'd2
  } slot_t;

endpackage

[rtl/core/rpnos_if.sv]
// Request and result channel interfaces of the RPN operand stack.
`timescale 1ns / 1ps
interface rpnos_in_if import rpnos_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [DATA_W-1:0] operand_value;
  logic [CNT_W-1:0]  operand_count;

  modport source (output valid, kind, operand_value, operand_count, input ready);
  modport sink   (input valid, kind, operand_value, operand_count, output ready);
endinterface

interface rpnos_out_if import rpnos_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DATA_W-1:0]    result_value;
  logic [ENTRIES_W-1:0] entries_now;
  logic [ERR_W-1:0]     error_code;

  modport source (output valid, result_value, entries_now, error_code, input ready);
  modport sink   (input valid, result_value, entries_now, error_code, output ready);
endinterface

[rtl/core/rpn_operand_stack_core.sv]
// Each request leaves S_IDLE for a pop step per popped word or one pick step, a load step after
// the pops or the pick (pop, drop, pick, over, swap, roll), a push step per pushed word, then
// S_DONE; pushes after an underflow are skipped. Dropn, clear and depth go straight to S_DONE.
// One request at a time; a stalled result waits in S_DONE. Dupn pushes its words through the
// single write port of the store, which takes one push per cycle.
// Reset clears the entry count, flags and handshake state; the store is not cleared.
`timescale 1ns / 1ps
module rpn_operand_stack_core import rpnos_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  rpnos_in_if.sink   in_ch,
  rpnos_out_if.source out_ch
);

  localparam int CW   = $clog2(STACK_DEPTH + 1);
  localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CMPW = (CW > CNT_W) ? CW : CNT_W;

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 under_r, under_nxt;
  logic                 over_r, over_nxt;
  logic                 supp_r, supp_nxt;
  logic                 rd_pend_r, rd_pend_nxt;
  slot_t                rd_slot_r, rd_slot_nxt;
  logic                 out_valid_r, out_valid_nxt;

  kind_t                kind_r, kind_nxt;
  logic [DATA_W-1:0]    val_r, val_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [1:0]           pops_left_r, pops_left_nxt;
  logic [CNT_W-1:0]     push_left_r, push_left_nxt;
  slot_t                pop_sel_r, pop_sel_nxt;
  logic [1:0]           push_idx_r, push_idx_nxt;
  logic [DATA_W-1:0]    a_r, b_r, c_r;
  logic [DATA_W-1:0]    res_r, res_nxt;
  logic [ENTRIES_W-1:0] ent_r, ent_nxt;
  err_t                 err_r, err_nxt;

  logic                 mem_we, mem_re;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [DATA_W-1:0]    push_val;
  logic [CMPW-1:0]      count_ext, cnt_ext, pos_ext;
  logic                 in_fire, out_free;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = res_r;
  assign out_ch.entries_now  = ent_r;
  assign out_ch.error_code   = err_r;

  assign count_ext = CMPW'(count_r);
  assign cnt_ext   = CMPW'(in_ch.operand_count);
  assign pos_ext   = (kind_r == KIND_OVER) ? CMPW'(2) : CMPW'(cnt_r);

  // Order of the pushes: swap puts back a then b, roll a, c then b.
  always_comb begin
    push_val = val_r;
    case (kind_r)
      KIND_OVER: push_val = a_r;
      KIND_SWAP: push_val = (push_idx_r == 2'd0) ? a_r : b_r;
      KIND_ROLL: begin
        case (push_idx_r)
          2'd0:    push_val = a_r;
          2'd1:    push_val = c_r;
          default: push_val = b_r;
        endcase
      end
      default: push_val = val_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    under_nxt     = under_r;
    over_nxt      = over_r;
    supp_nxt      = supp_r;
    rd_pend_nxt   = 1'b0;
    rd_slot_nxt   = rd_slot_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    kind_nxt      = kind_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    pops_left_nxt = pops_left_r;
    push_left_nxt = push_left_r;
    pop_sel_nxt   = pop_sel_r;
    push_idx_nxt  = push_idx_r;
    res_nxt       = res_r;
    ent_nxt       = ent_r;
    err_nxt       = err_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    wr_addr       = AW'(count_r);
    rd_addr       = AW'(count_r - 1'b1);

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          kind_nxt      = kind_t'(in_ch.kind);
          val_nxt       = in_ch.operand_value;
          cnt_nxt       = in_ch.operand_count;
          under_nxt     = 1'b0;
          over_nxt      = 1'b0;
          supp_nxt      = 1'b0;
          pop_sel_nxt   = SLOT_A;
          push_idx_nxt  = 2'd0;
          pops_left_nxt = 2'd0;
          push_left_nxt = '0;
          state_nxt     = S_DONE;
          case (kind_t'(in_ch.kind))
            KIND_PUSH: begin
              push_left_nxt = CNT_W'(1);
              state_nxt     = S_PUSH;
            end
            KIND_POP, KIND_DROP: begin
              pops_left_nxt = 2'd1;
              state_nxt     = S_POP;
            end
            KIND_PICK:  state_nxt = S_PICK;
            KIND_OVER: begin
              push_left_nxt = CNT_W'(1);
              state_nxt     = S_PICK;
            end
            KIND_DUP: begin
              push_left_nxt = CNT_W'(2);
              state_nxt     = S_PUSH;
            end
            KIND_DUP2: begin
              push_left_nxt = CNT_W'(3);
              state_nxt     = S_PUSH;
            end
            KIND_DUPN: begin
              push_left_nxt = in_ch.operand_count;
              state_nxt     = S_PUSH;
            end
            KIND_DROPN: begin
              // Repeated pops collapse into one subtraction, clamped at empty.
              if (cnt_ext > count_ext) begin
                count_nxt = '0;
                under_nxt = 1'b1;
              end else begin
                count_nxt = CW'(count_ext - cnt_ext);
              end
            end
            KIND_CLEAR: count_nxt = '0;
            KIND_SWAP: begin
              pops_left_nxt = 2'd2;
              push_left_nxt = CNT_W'(2);
              state_nxt     = S_POP;
            end
            KIND_ROLL: begin
              pops_left_nxt = 2'd3;
              push_left_nxt = CNT_W'(3);
              state_nxt     = S_POP;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_POP: begin
        if (count_r == '0) begin
          under_nxt = 1'b1;
          supp_nxt  = 1'b1;
        end else begin
          mem_re      = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_slot_nxt = pop_sel_r;
          count_nxt   = count_r - 1'b1;
        end
        pop_sel_nxt   = slot_t'(pop_sel_r + 2'd1);
        pops_left_nxt = pops_left_r - 2'd1;
        if (pops_left_r == 2'd1) begin
          state_nxt = S_LOAD;
        end
      end

      S_PICK: begin
        rd_addr = AW'(count_ext - pos_ext);
        if (pos_ext == '0 || pos_ext > count_ext) begin
          under_nxt = 1'b1;
          supp_nxt  = 1'b1;
        end else begin
          mem_re      = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_slot_nxt = SLOT_A;
        end
        state_nxt = S_LOAD;
      end

      // The last word read lands in its holding register during this cycle.
      S_LOAD: begin
        state_nxt = (push_left_r == '0 || supp_r) ? S_DONE : S_PUSH;
      end

      S_PUSH: begin
        if (supp_r || push_left_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          if (count_r == CW'(STACK_DEPTH)) begin
            over_nxt = 1'b1;
          end else begin
            mem_we    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          push_left_nxt = push_left_r - 1'b1;
          push_idx_nxt  = push_idx_r + 2'd1;
          if (push_left_r == CNT_W'(1)) begin
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          case (kind_r)
            KIND_POP, KIND_PICK: res_nxt = under_r ? '0 : a_r;
            KIND_DEPTH:          res_nxt = DATA_W'(count_r);
            default:             res_nxt = '0;
          endcase
          ent_nxt       = count_ext[ENTRIES_W-1:0];
          err_nxt       = under_r ? ERR_UNDER : (over_r ? ERR_OVER : ERR_NONE);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      under_r     <= 1'b0;
      over_r      <= 1'b0;
      supp_r      <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      under_r     <= under_nxt;
      over_r      <= over_nxt;
      supp_r      <= supp_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    val_r       <= val_nxt;
    cnt_r       <= cnt_nxt;
    pops_left_r <= pops_left_nxt;
    push_left_r <= push_left_nxt;
    pop_sel_r   <= pop_sel_nxt;
    push_idx_r  <= push_idx_nxt;
    rd_slot_r   <= rd_slot_nxt;
    res_r       <= res_nxt;
    ent_r       <= ent_nxt;
    err_r       <= err_nxt;
    if (rd_pend_r) begin
      case (rd_slot_r)
        SLOT_A:  a_r <= rd_data_r;
        SLOT_B:  b_r <= rd_data_r;
        default: c_r <= rd_data_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= push_val;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("entry count beyond stack depth");

  a_no_write_suppressed: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !supp_r)
    else $error("store written after an underflow in the same request");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("new request taken while one is in progress");

endmodule

[dv/rpn_operand_stack_core_tb.sv]
// Self-checking testbench for the RPN operand stack core, with random handshake stalls.
`timescale 1ns / 1ps
module rpn_operand_stack_core_tb;
  import rpnos_pkg::*;

  localparam int STACK_DEPTH     = 64;
  localparam int RANDOM_REQUESTS = 1075;
  localparam int QUIET_TAIL      = 150;
  localparam int STALL_LIMIT     = 2000;
  localparam int TAIL_CYCLES     = 20;
  localparam int PRINT_LIMIT     = 40;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  count;
    bit                drain;
  } stack_request_t;

  typedef struct {
    logic [DATA_W-1:0]    value;
    logic [ENTRIES_W-1:0] entries;
    err_t                 err;
  } stack_result_t;

  logic clk;
  logic rst_n;

  rpnos_in_if  in_ch();
  rpnos_out_if out_ch();

  rpn_operand_stack_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stack_request_t pending_requests[$];
  stack_result_t  expected_results[$];
  stack_request_t live_request;

  // Shadow copy of the stack, advanced once per accepted request.
  logic [DATA_W-1:0] stack_words [STACK_DEPTH];
  int unsigned       stack_level;
  bit                push_blocked;
  bit                saw_underflow;
  bit                saw_overflow;

  int total_requests;
  int requests_accepted;
  int results_seen;
  int mismatch_count;
  int send_gap;
  int sink_gap;
  int stall_cycles;
  bit timed_out;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("[%0t] MISMATCH: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  function automatic void model_push(input logic [DATA_W-1:0] word);
    if (push_blocked) return;
    if (stack_level >= STACK_DEPTH) begin
      saw_overflow = 1'b1;
      return;
    end
    stack_words[stack_level] = word;
    stack_level++;
  endfunction

  function automatic logic [DATA_W-1:0] model_pop();
    if (stack_level == 0) begin
      saw_underflow = 1'b1;
      push_blocked  = 1'b1;
      return '0;
    end
    stack_level--;
    return stack_words[stack_level];
  endfunction

  function automatic logic [DATA_W-1:0] model_pick(input int unsigned pos);
    if (pos == 0 || pos > stack_level) begin
      saw_underflow = 1'b1;
      push_blocked  = 1'b1;
      return '0;
    end
    return stack_words[stack_level - pos];
  endfunction

  function automatic void predict_result(input stack_request_t req);
    logic [DATA_W-1:0] a, b, c, answer;
    stack_result_t     r;
    answer        = '0;
    push_blocked  = 1'b0;
    saw_underflow = 1'b0;
    saw_overflow  = 1'b0;
    case (req.kind)
      KIND_PUSH:  model_push(req.value);
      KIND_POP:   answer = model_pop();
      KIND_PICK:  answer = model_pick(req.count);
      KIND_DROP:  void'(model_pop());
      KIND_DUP:   repeat (2) model_push(req.value);
      KIND_DUP2:  repeat (3) model_push(req.value);
      KIND_DUPN:  repeat (req.count) model_push(req.value);
      KIND_DROPN: repeat (req.count) void'(model_pop());
      KIND_CLEAR: stack_level = 0;
      KIND_OVER: begin
        a = model_pick(2);
        model_push(a);
      end
      KIND_DEPTH: answer = DATA_W'(stack_level);
      KIND_SWAP: begin
        a = model_pop();
        b = model_pop();
        model_push(a);
        model_push(b);
      end
      KIND_ROLL: begin
        a = model_pop();
        b = model_pop();
        c = model_pop();
        model_push(a);
        model_push(c);
        model_push(b);
      end
      default: ;
    endcase
    r.value   = answer;
    r.entries = ENTRIES_W'(stack_level);
    r.err     = saw_underflow ? ERR_UNDER : (saw_overflow ? ERR_OVER : ERR_NONE);
    expected_results.push_back(r);
  endfunction

  function automatic bit bursts_allowed(input int n);
    return (n + QUIET_TAIL < total_requests) && ((n / 128) % 4 != 3);
  endfunction

  function automatic logic [KIND_W-1:0] choose_kind(input bit growing);
    int unsigned dice;
    dice = $urandom_range(0, 99);
    if (dice < 3) return KIND_W'($urandom_range(2**KIND_W - 1, int'(KIND_ROLL) + 1));
    if (growing) begin
      if (dice < 35) return KIND_PUSH;
      if (dice < 43) return KIND_DUP;
      if (dice < 50) return KIND_DUP2;
      if (dice < 56) return KIND_DUPN;
      if (dice < 63) return KIND_OVER;
      if (dice < 70) return KIND_POP;
      if (dice < 77) return KIND_PICK;
      if (dice < 81) return KIND_DROP;
      if (dice < 86) return KIND_SWAP;
      if (dice < 91) return KIND_ROLL;
      if (dice < 95) return KIND_DEPTH;
      if (dice < 98) return KIND_DROPN;
      return KIND_CLEAR;
    end
    if (dice < 12) return KIND_PUSH;
    if (dice < 15) return KIND_DUP;
    if (dice < 18) return KIND_DUPN;
    if (dice < 23) return KIND_OVER;
    if (dice < 40) return KIND_POP;
    if (dice < 52) return KIND_PICK;
    if (dice < 64) return KIND_DROP;
    if (dice < 72) return KIND_DROPN;
    if (dice < 80) return KIND_SWAP;
    if (dice < 88) return KIND_ROLL;
    if (dice < 94) return KIND_DEPTH;
    if (dice < 97) return KIND_DUP2;
    return KIND_CLEAR;
  endfunction

  task automatic add_request(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] value,
                             input logic [CNT_W-1:0] count, input bit drain);
    stack_request_t req;
    req.kind  = kind;
    req.value = value;
    req.count = count;
    req.drain = drain;
    pending_requests.push_back(req);
  endtask

  task automatic build_stimulus();
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  count;
    // Failing operations on an empty stack first.
    add_request(KIND_POP,   '0, '0, 1'b0);
    add_request(KIND_DROP,  '0, '0, 1'b0);
    add_request(KIND_PICK,  '0, 8'd1, 1'b0);
    add_request(KIND_OVER,  '0, '0, 1'b0);
    add_request(KIND_DROPN, '0, 8'd3, 1'b0);
    add_request(KIND_PUSH,  '1, '0, 1'b0);
    add_request(KIND_PUSH,  '0, '1, 1'b0);
    add_request(KIND_PUSH,  {(DATA_W/8){8'hA5}}, '0, 1'b0);
    add_request(KIND_PICK,  '0, 8'd0, 1'b0);
    add_request(KIND_PICK,  '0, 8'd3, 1'b0);
    add_request(KIND_PICK,  '0, '1, 1'b0);
    add_request(KIND_OVER,  '0, '0, 1'b0);
    add_request(KIND_SWAP,  '0, '0, 1'b0);
    add_request(KIND_ROLL,  '0, '0, 1'b0);
    add_request(KIND_DEPTH, '0, '0, 1'b0);
    add_request(KIND_DUP,   {(DATA_W/8){8'h5A}}, '0, 1'b0);
    add_request(KIND_DUP2,  {$urandom(), $urandom()}, '0, 1'b0);
    add_request(KIND_DUPN,  {$urandom(), $urandom()}, 8'd0, 1'b0);
    // Fills the store and runs into overflow, then over and depth on a full stack.
    add_request(KIND_DUPN,  {$urandom(), $urandom()}, '1, 1'b0);
    add_request(KIND_OVER,  '0, '0, 1'b0);
    add_request(KIND_DEPTH, '0, '0, 1'b0);
    add_request(KIND_DROPN, '0, '1, 1'b1);
    // Two-word roll and one-word swap lose the words that were popped.
    add_request(KIND_DUP,   {$urandom(), $urandom()}, '0, 1'b0);
    add_request(KIND_ROLL,  '0, '0, 1'b0);
    add_request(KIND_PUSH,  {$urandom(), $urandom()}, '0, 1'b0);
    add_request(KIND_SWAP,  '0, '0, 1'b0);
    add_request(KIND_DUP,   {$urandom(), $urandom()}, '0, 1'b0);
    add_request(KIND_CLEAR, '0, '0, 1'b0);
    add_request('1,         {$urandom(), $urandom()}, '1, 1'b0);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      kind = choose_kind(((n / 48) % 2) == 0);
      case ($urandom_range(0, 15))
        0:       value = '1;
        1:       value = '0;
        default: value = {$urandom(), $urandom()};
      endcase
      if (kind == KIND_DUPN || kind == KIND_DROPN) begin
        count = ($urandom_range(0, 15) == 0) ? CNT_W'($urandom_range(0, 255))
                                             : CNT_W'($urandom_range(0, 6));
      end else if (kind == KIND_PICK) begin
        count = ($urandom_range(0, 7) == 0) ? CNT_W'($urandom_range(0, 255))
                                            : CNT_W'($urandom_range(0, 9));
      end else begin
        count = CNT_W'($urandom_range(0, 255));
      end
      add_request(kind, value, count, (n % 300) == 150);
    end
    total_requests = pending_requests.size();
  endtask

  // Request driver.
  always @(posedge clk) begin
    bit take;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_result(live_request);
        requests_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        take = pending_requests.size() != 0;
        if (take && send_gap > 0) begin
          send_gap--;
          take = 1'b0;
        end else if (take && bursts_allowed(requests_accepted) &&
                     $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 5);
          take     = 1'b0;
        end
        // A marked request is held back until the stack has answered everything.
        if (take && pending_requests[0].drain && expected_results.size() != 0) begin
          take = 1'b0;
        end
        if (take) begin
          live_request = pending_requests.pop_front();
          in_ch.kind          <= live_request.kind;
          in_ch.operand_value <= live_request.value;
          in_ch.operand_count <= live_request.count;
        end
        in_ch.valid <= take;
      end
    end
  end

  // Result monitor and ready generation.
  always @(posedge clk) begin
    stack_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result value=%h entries=%0d err=%0d",
                                    out_ch.result_value, out_ch.entries_now,
                                    out_ch.error_code));
        end else begin
          want = expected_results.pop_front();
          if (out_ch.result_value !== want.value) begin
            report_mismatch($sformatf("result %0d value %h, expected %h", results_seen,
                                      out_ch.result_value, want.value));
          end
          if (out_ch.entries_now !== want.entries) begin
            report_mismatch($sformatf("result %0d entries %0d, expected %0d", results_seen,
                                      out_ch.entries_now, want.entries));
          end
          if (out_ch.error_code !== want.err) begin
            report_mismatch($sformatf("result %0d error %0d, expected %s", results_seen,
                                      out_ch.error_code, want.err.name()));
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        out_ch.ready <= 1'b0;
      end else if (bursts_allowed(results_seen) && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on handshake progress.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles == STALL_LIMIT && !timed_out) begin
        report_mismatch($sformatf("no progress for %0d cycles, %0d results outstanding",
                                  STALL_LIMIT, expected_results.size()));
        timed_out = 1'b1;
      end
    end
  end

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.kind          = '0;
    in_ch.operand_value = '0;
    in_ch.operand_count = '0;
    out_ch.ready        = 1'b0;
    stack_level         = 0;
    push_blocked        = 1'b0;
    requests_accepted   = 0;
    results_seen        = 0;
    mismatch_count      = 0;
    stall_cycles        = 0;
    timed_out           = 1'b0;
    build_stimulus();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while ((requests_accepted < total_requests || expected_results.size() != 0) &&
           !timed_out) begin
      @(posedge clk);
    end
    if (!timed_out) begin
      repeat (TAIL_CYCLES) @(posedge clk);
    end
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/rpnos_pkg.sv
rtl/core/rpnos_if.sv
rtl/core/rpn_operand_stack_core.sv
dv/rpn_operand_stack_core_tb.sv
